// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked during reset
`define QFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs while reset is asserted
`define QFT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/qft_pkg.sv =====
// Shared types, constants and helpers for the quoted field tokenizer.
// No dependencies; every RTL module imports this package.
`default_nettype none

package qft_pkg;

    localparam int unsigned PENDING_DEPTH_DEF = 16;
    localparam int unsigned CMD_FIFO_DEPTH    = 4;

    localparam logic [7:0] NUL_CH      = 8'h00;
    localparam logic [7:0] QUOTE_CH    = 8'h22;
    localparam logic [7:0] CR_CH       = 8'h0D;
    localparam logic [7:0] LF_CH       = 8'h0A;
    localparam logic [7:0] DELIM_RESET = 8'h3A;

    // One command per input beat that needs work in the back end
    typedef struct packed {
        logic       store;    // park a trailing blank in the pending buffer
        logic       emit;     // flush pending blanks, then emit ch
        logic [7:0] ch;
        logic       fe1;      // field end from the byte itself
        logic       fe1_rec;  // ... which also closes the record
        logic       fe2;      // record end forced by end of line
        logic       ovf;      // sticky overflow as seen by this beat
    } qft_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FLUSH,
        BK_CHAR,
        BK_FE1,
        BK_FE2
    } qft_bk_state_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qft_front.sv =====
// Front end: accepts bytes, runs the quote/field/record rules, issues commands.
// Depends on qft_pkg.
`default_nettype none

module qft_front #(
    parameter int unsigned PENDING_DEPTH = qft_pkg::PENDING_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       in_byte,
    input  wire logic             end_of_line,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             fifo_full,
    output logic                  push,
    output qft_pkg::qft_cmd_t     cmd
);
    import qft_pkg::*;

    localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

    logic [7:0]    delim_reg;
    logic          in_quotes_reg, in_quotes_next;
    logic          quote_pending_reg, quote_pending_next;
    logic          field_nonempty_reg, field_nonempty_next;
    logic          field_emitted_reg, field_emitted_next;
    logic [CW-1:0] pend_cnt_reg, pend_cnt_next;
    logic          line_done_reg, line_done_next;
    logic          overflow_reg, overflow_next;

    logic accept;
    logic consumed;
    logic ended;
    logic do_push;

    assign in_stall  = fifo_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign push      = accept && (cmd.store || cmd.emit || cmd.fe1 || cmd.fe2);

    always_comb
    begin
        in_quotes_next      = in_quotes_reg;
        quote_pending_next  = quote_pending_reg;
        field_nonempty_next = field_nonempty_reg;
        field_emitted_next  = field_emitted_reg;
        pend_cnt_next       = pend_cnt_reg;
        line_done_next      = line_done_reg;
        overflow_next       = overflow_reg;
        consumed            = 1'b0;
        ended               = 1'b0;
        do_push             = 1'b0;
        cmd                 = '0;
        cmd.ch              = in_byte;

        if (line_done_reg)
        begin
            // swallow the rest of the line; the end_of_line beat rearms
            if (end_of_line)
            begin
                line_done_next      = 1'b0;
                in_quotes_next      = 1'b0;
                quote_pending_next  = 1'b0;
                field_nonempty_next = 1'b0;
                field_emitted_next  = 1'b0;
                pend_cnt_next       = '0;
            end
        end
        else
        begin
            // one-byte lookahead on a quote inside quotes
            if (quote_pending_reg)
            begin
                quote_pending_next = 1'b0;
                if (in_byte == QUOTE_CH)
                begin
                    do_push  = 1'b1;
                    consumed = 1'b1;
                end
                else
                begin
                    in_quotes_next = 1'b0;
                end
            end

            if (!consumed)
            begin
                if (in_byte == NUL_CH)
                begin
                    cmd.fe1     = 1'b1;
                    cmd.fe1_rec = 1'b1;
                    ended       = 1'b1;
                end
                else if (!in_quotes_next && !field_nonempty_reg && in_byte == QUOTE_CH)
                begin
                    in_quotes_next = 1'b1;
                end
                else if (in_quotes_next && in_byte == QUOTE_CH)
                begin
                    quote_pending_next = 1'b1;
                end
                else if (!in_quotes_next && in_byte == delim_reg)
                begin
                    cmd.fe1 = 1'b1;
                end
                else if (!in_quotes_next && (in_byte == CR_CH || in_byte == LF_CH))
                begin
                    cmd.fe1     = 1'b1;
                    cmd.fe1_rec = 1'b1;
                    ended       = 1'b1;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end

            if (do_push)
            begin
                field_nonempty_next = 1'b1;
                if (is_blank(in_byte))
                begin
                    // leading blanks vanish; trailing ones wait for a later char
                    if (field_emitted_reg)
                    begin
                        if (pend_cnt_reg < CW'(PENDING_DEPTH))
                        begin
                            cmd.store     = 1'b1;
                            pend_cnt_next = pend_cnt_reg + CW'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    cmd.emit           = 1'b1;
                    pend_cnt_next      = '0;
                    field_emitted_next = 1'b1;
                end
            end

            if (cmd.fe1)
            begin
                field_nonempty_next = 1'b0;
                field_emitted_next  = 1'b0;
                pend_cnt_next       = '0;
                if (cmd.fe1_rec)
                begin
                    in_quotes_next     = 1'b0;
                    quote_pending_next = 1'b0;
                end
            end

            if (ended)
            begin
                if (!end_of_line)
                begin
                    line_done_next = 1'b1;
                end
            end
            else if (end_of_line)
            begin
                quote_pending_next  = 1'b0;
                in_quotes_next      = 1'b0;
                field_nonempty_next = 1'b0;
                field_emitted_next  = 1'b0;
                pend_cnt_next       = '0;
                cmd.fe2             = 1'b1;
                cmd.store           = 1'b0;  // the field is cleared anyway
            end
        end

        cmd.ovf = overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg          <= DELIM_RESET;
            in_quotes_reg      <= 1'b0;
            quote_pending_reg  <= 1'b0;
            field_nonempty_reg <= 1'b0;
            field_emitted_reg  <= 1'b0;
            pend_cnt_reg       <= '0;
            line_done_reg      <= 1'b0;
            overflow_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                delim_reg <= cfg_data;
            end
            if (accept)
            begin
                in_quotes_reg      <= in_quotes_next;
                quote_pending_reg  <= quote_pending_next;
                field_nonempty_reg <= field_nonempty_next;
                field_emitted_reg  <= field_emitted_next;
                pend_cnt_reg       <= pend_cnt_next;
                line_done_reg      <= line_done_next;
                overflow_reg       <= overflow_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qft_cmd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on qft_pkg (command type and depth).
`default_nettype none

module qft_cmd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire qft_pkg::qft_cmd_t din,
    input  wire logic              pop,
    output qft_pkg::qft_cmd_t      head,
    output logic                   full,
    output logic                   empty
);
    import qft_pkg::*;

    localparam int unsigned PW = $clog2(CMD_FIFO_DEPTH);
    localparam int unsigned NW = $clog2(CMD_FIFO_DEPTH + 1);

    qft_cmd_t      slot_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] fill_reg;

    assign full  = (fill_reg == NW'(CMD_FIFO_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qft_back.sv =====
// Back end: runs queued commands, owns the pending-blank memory, drives results.
// Depends on qft_pkg.
`default_nettype none

module qft_back #(
    parameter int unsigned PENDING_DEPTH = qft_pkg::PENDING_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qft_pkg::qft_cmd_t head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_char,
    output logic                   char_valid,
    output logic                   field_end,
    output logic                   record_end,
    output logic                   overflow,
    output logic                   last_of_run
);
    import qft_pkg::*;

    localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    qft_bk_state_t state_reg, state_next;
    qft_cmd_t      cmd_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    pend_mem [PENDING_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;

    logic          slot_free;
    logic          flush_last;
    logic          res_load;
    logic [7:0]    res_char;
    logic          res_cv;
    logic          res_fe;
    logic          res_re;
    logic          res_last;

    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          char_valid_reg;
    logic          field_end_reg;
    logic          record_end_reg;
    logic          overflow_reg;
    logic          last_of_run_reg;

    assign slot_free  = !out_valid_reg || !out_stall;
    assign flush_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    if (head.emit)
                    begin
                        state_next = (cnt_reg != '0) ? BK_FLUSH : BK_CHAR;
                    end
                    else if (head.fe1)
                    begin
                        state_next = BK_FE1;
                    end
                    else if (head.fe2)
                    begin
                        state_next = BK_FE2;
                    end
                end
            end
            BK_FLUSH:
            begin
                if (slot_free && flush_last)
                begin
                    state_next = BK_CHAR;
                end
            end
            BK_CHAR, BK_FE1:
            begin
                if (slot_free)
                begin
                    state_next = cmd_reg.fe2 ? BK_FE2 : BK_IDLE;
                end
            end
            BK_FE2:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        res_load = 1'b0;
        res_char = '0;
        res_cv   = 1'b0;
        res_fe   = 1'b0;
        res_re   = 1'b0;
        res_last = 1'b0;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        rd_addr  = '0;
        case (state_reg)
            BK_IDLE:
            begin
                idx_next = '0;
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.store && !head.emit && !head.fe1 && !head.fe2)
                    begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            BK_FLUSH:
            begin
                // read data always tracks idx_reg; prefetch the next entry on a beat
                rd_addr = idx_reg;
                if (slot_free)
                begin
                    res_load = 1'b1;
                    res_char = rd_data_reg;
                    res_cv   = 1'b1;
                    if (!flush_last)
                    begin
                        idx_next = idx_reg + IW'(1);
                        rd_addr  = idx_reg + IW'(1);
                    end
                end
            end
            BK_CHAR:
            begin
                if (slot_free)
                begin
                    res_load = 1'b1;
                    res_char = cmd_reg.ch;
                    res_cv   = 1'b1;
                    res_last = !cmd_reg.fe2;
                    cnt_next = '0;
                end
            end
            BK_FE1:
            begin
                if (slot_free)
                begin
                    res_load = 1'b1;
                    res_fe   = 1'b1;
                    res_re   = cmd_reg.fe1_rec;
                    res_last = !cmd_reg.fe2;
                    cnt_next = '0;
                end
            end
            BK_FE2:
            begin
                if (slot_free)
                begin
                    res_load = 1'b1;
                    res_fe   = 1'b1;
                    res_re   = 1'b1;
                    res_last = 1'b1;
                    cnt_next = '0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pend_mem[cnt_reg[IW-1:0]] <= head.ch;
        end
        rd_data_reg <= pend_mem[rd_addr];
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (res_load)
        begin
            out_char_reg    <= res_char;
            char_valid_reg  <= res_cv;
            field_end_reg   <= res_fe;
            record_end_reg  <= res_re;
            overflow_reg    <= cmd_reg.ovf;
            last_of_run_reg <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign char_valid  = char_valid_reg;
    assign field_end   = field_end_reg;
    assign record_end  = record_end_reg;
    assign overflow    = overflow_reg;
    assign last_of_run = last_of_run_reg;

endmodule

`default_nettype wire

// ===== rtl/quoted_field_tokenizer_core.sv =====
// Top level of the quoted field tokenizer: front end, command queue, back end.
// Depends on qft_pkg, qft_front, qft_cmd_fifo, qft_back and assert_macros.svh.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   in      | in_valid / in_stall   | in_byte, end_of_line
//   out     | out_valid / out_stall | out_char, char_valid, field_end, record_end,
//           |                       | overflow, last_of_run
//   cfg     | cfg_valid / cfg_ready | cfg_data (delimiter)
//
// The front end takes one byte a cycle while the 4-entry command queue has room.
// The back end pops each queued command in its idle state, then drives one result
// per parked blank, one for the character and one per field end; a store command only
// parks its blank, and dropped blanks and quotes queue no command of their own.
// Reset is asynchronous and needs no clearing pass; the delimiter returns to ':'.
// out_stall holds the output register; a full queue raises in_stall.
`default_nettype none
`include "assert_macros.svh"

module quoted_field_tokenizer_core #(
    parameter int unsigned PENDING_DEPTH = qft_pkg::PENDING_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_line,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_char,
    output logic            char_valid,
    output logic            field_end,
    output logic            record_end,
    output logic            overflow,
    output logic            last_of_run,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);
    import qft_pkg::*;

    qft_cmd_t push_cmd;
    qft_cmd_t head_cmd;
    logic     fifo_push;
    logic     fifo_pop;
    logic     fifo_full;
    logic     fifo_empty;

    qft_front #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_line (end_of_line),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fifo_full   (fifo_full),
        .push        (fifo_push),
        .cmd         (push_cmd)
    );

    qft_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .din   (push_cmd),
        .pop   (fifo_pop),
        .head  (head_cmd),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    qft_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .empty       (fifo_empty),
        .pop         (fifo_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .field_end   (field_end),
        .record_end  (record_end),
        .overflow    (overflow),
        .last_of_run (last_of_run)
    );

    `QFT_ASSERT(a_no_push_when_full, fifo_push |-> !fifo_full, "command pushed into full queue")
    `QFT_ASSERT(a_no_pop_when_empty, fifo_pop |-> !fifo_empty, "command popped from empty queue")
    `QFT_ASSERT(a_record_closes_field, (out_valid && record_end) |-> (field_end && !char_valid), "record end beat without field end")
    `QFT_ASSERT(a_overflow_sticky, (out_valid && !out_stall && overflow) |=> (!out_valid || overflow), "overflow flag dropped")

endmodule

`default_nettype wire

// ===== tb/qft_token_checker.sv =====
// Token checker for quoted_field_tokenizer_core: mirrors the tokenizer on every accepted
// input beat and compares each accepted output beat with the oldest predicted token.
// Depends on qft_pkg for the character constants and the blank buffer depth.
`timescale 1ns / 100ps

module qft_token_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_line,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_char,
    input  logic       char_valid,
    input  logic       field_end,
    input  logic       record_end,
    input  logic       overflow,
    input  logic       last_of_run,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         tokens_left,
    output int         tokens_checked
);
    import qft_pkg::*;

    localparam int HOLD_DEPTH = PENDING_DEPTH_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       fe;
        logic       re;
        logic       ovf;
        logic       last;
    } token_t;

    token_t     token_q[$];
    token_t     beat_toks[$];
    logic [7:0] delim = DELIM_RESET;
    logic       quoted = 1'b0;
    logic       quote_held = 1'b0;
    logic       field_started = 1'b0;
    logic       field_printed = 1'b0;
    logic       rec_closed = 1'b0;
    logic       ovf_sticky = 1'b0;
    logic [7:0] held_ws [HOLD_DEPTH];
    int         held_cnt = 0;
    int         fail_cnt = 0;
    int         check_cnt = 0;

    initial
    begin
        mismatches = 0;
        tokens_left = 0;
        tokens_checked = 0;
    end

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void emit(input logic [7:0] c, input logic cv, input logic fe,
                                 input logic re);
        token_t t;
        t.ch   = cv ? c : 8'h00;
        t.cv   = cv;
        t.fe   = fe;
        t.re   = re;
        t.ovf  = ovf_sticky;
        t.last = 1'b0;
        beat_toks = {beat_toks, t};
    endfunction

    function automatic void drop_field();
        field_started = 1'b0;
        field_printed = 1'b0;
        held_cnt      = 0;
    endfunction

    function automatic void drop_line();
        drop_field();
        quoted     = 1'b0;
        quote_held = 1'b0;
    endfunction

    // trailing blanks wait until a later non-blank shows they were inside the field
    function automatic void take_char(input logic [7:0] c);
        field_started = 1'b1;
        if (is_ws(c))
        begin
            if (field_printed)
            begin
                if (held_cnt < HOLD_DEPTH)
                begin
                    held_ws[held_cnt] = c;
                    held_cnt++;
                end
                else
                    ovf_sticky = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < held_cnt; i++)
                emit(held_ws[i], 1'b1, 1'b0, 1'b0);
            held_cnt      = 0;
            field_printed = 1'b1;
            emit(c, 1'b1, 1'b0, 1'b0);
        end
    endfunction

    function automatic void close_field(input logic rec);
        emit(8'h00, 1'b0, 1'b1, rec);
        if (rec)
            drop_line();
        else
            drop_field();
    endfunction

    function automatic void predict_beat(input logic [7:0] c, input logic eol);
        logic   consumed;
        logic   ended;
        consumed = 1'b0;
        ended    = 1'b0;
        beat_toks.delete();
        if (rec_closed)
        begin
            // rest of the line is ignored; the end-of-line beat re-arms
            if (eol)
            begin
                rec_closed = 1'b0;
                drop_line();
            end
        end
        else
        begin
            if (quote_held)
            begin
                quote_held = 1'b0;
                if (c == QUOTE_CH)
                begin
                    take_char(c);
                    consumed = 1'b1;
                end
                else
                    quoted = 1'b0;
            end
            if (!consumed)
            begin
                if (c == NUL_CH)
                begin
                    close_field(1'b1);
                    ended = 1'b1;
                end
                else if (!quoted && !field_started && c == QUOTE_CH)
                    quoted = 1'b1;
                else if (quoted && c == QUOTE_CH)
                    quote_held = 1'b1;
                else if (!quoted && c == delim)
                    close_field(1'b0);
                else if (!quoted && (c == CR_CH || c == LF_CH))
                begin
                    close_field(1'b1);
                    ended = 1'b1;
                end
                else
                    take_char(c);
            end
            if (ended)
            begin
                if (!eol)
                    rec_closed = 1'b1;
            end
            else if (eol)
            begin
                quote_held = 1'b0;
                quoted     = 1'b0;
                close_field(1'b1);
            end
        end
        if (beat_toks.size() > 0)
            beat_toks[beat_toks.size() - 1].last = 1'b1;
        token_q = {token_q, beat_toks};
        beat_toks.delete();
    endfunction

    function automatic string tok_str(input token_t t);
        return $sformatf("char %02h valid %b field_end %b record_end %b overflow %b last %b",
                         t.ch, t.cv, t.fe, t.re, t.ovf, t.last);
    endfunction

    always @(posedge clk)
    begin : watch_beats
        token_t want;
        token_t got;
        if (!rst_n)
        begin
            delim      = DELIM_RESET;
            rec_closed = 1'b0;
            ovf_sticky = 1'b0;
            drop_line();
            token_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                delim = cfg_data;
            if (in_valid && !in_stall)
                predict_beat(in_byte, end_of_line);
            if (out_valid && !out_stall)
            begin
                got = {out_char, char_valid, field_end, record_end, overflow, last_of_run};
                if (token_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("%0t: output beat with nothing predicted: %s",
                                 $realtime, tok_str(got));
                end
                else
                begin
                    want = token_q.pop_front();
                    check_cnt++;
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                        begin
                            $display("%0t: token mismatch", $realtime);
                            $display("    expected %s", tok_str(want));
                            $display("    actual   %s", tok_str(got));
                        end
                    end
                end
            end
        end
        mismatches     <= fail_cnt;
        tokens_left    <= token_q.size();
        tokens_checked <= check_cnt;
    end

endmodule

// ===== tb/quoted_field_tokenizer_core_test.sv =====
// Testbench top for quoted_field_tokenizer_core: feeds CSV-like lines and noise, rewrites
// the delimiter between phases, applies back-pressure and gives the verdict.
// Depends on qft_pkg, the tokenizer RTL and qft_token_checker.
`timescale 1ns / 100ps

module quoted_field_tokenizer_core_test;
    import qft_pkg::*;

    localparam int HOLD_OFF    = 160;   // idle wait for the 4-beat command queue to empty
    localparam int QUIET_LIMIT = 5000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_line = 1'b0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data = 8'h00;
    wire        in_stall;
    wire        out_valid;
    wire  [7:0] out_char;
    wire        char_valid;
    wire        field_end;
    wire        record_end;
    wire        overflow;
    wire        last_of_run;
    wire        cfg_ready;
    int         mismatches;
    int         tokens_left;
    int         tokens_checked;

    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         beats_sent = 0;
    int         lines_sent = 0;
    int         quiet_cycles = 0;
    logic [7:0] delim_now = DELIM_RESET;
    logic [7:0] line_buf[$];

    quoted_field_tokenizer_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .field_end   (field_end),
        .record_end  (record_end),
        .overflow    (overflow),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    qft_token_checker token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .end_of_line    (end_of_line),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .char_valid     (char_valid),
        .field_end      (field_end),
        .record_end     (record_end),
        .overflow       (overflow),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .tokens_left    (tokens_left),
        .tokens_checked (tokens_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles, %0d tokens outstanding",
                     quiet_cycles, tokens_left);
            $display("quoted_field_tokenizer_core verification failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eol);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_line <= eol;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    task automatic flush_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_beat(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
        lines_sent++;
    endtask

    // wait for every predicted token, then for beats that produce none to drain
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_left != 0);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_delim(input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        delim_now = d;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 1));
        while (is_blank(c) || c == QUOTE_CH || c == delim_now);
        return c;
    endfunction

    // CR and LF are blanks only inside quotes; outside they end the record
    function automatic logic [7:0] pick_blank(input logic in_q);
        logic [7:0] c;
        do
        begin
            case ($urandom_range(5))
                0:       c = 8'h20;
                1:       c = 8'h09;
                2:       c = 8'h0B;
                3:       c = 8'h0C;
                4:       c = LF_CH;
                default: c = CR_CH;
            endcase
        end
        while (!in_q && (c == LF_CH || c == CR_CH || c == delim_now));
        return c;
    endfunction

    function automatic void push_blanks(input int n, input logic in_q);
        repeat (n) add_byte(pick_blank(in_q));
    endfunction

    function automatic int pick_run(input int max_run);
        return ($urandom_range(3) == 0) ? $urandom_range(max_run) : $urandom_range(2);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0:       return QUOTE_CH;
            1:       return delim_now;
            2:       return $urandom_range(1) ? CR_CH : LF_CH;
            3:       return NUL_CH;
            4:       return pick_blank(1'b1);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void gen_field(input int max_run, input logic quote_at_end);
        int kind;
        logic literal_delim;
        kind = quote_at_end ? 4 : $urandom_range(5);
        literal_delim = !(delim_now == QUOTE_CH || delim_now == NUL_CH || is_blank(delim_now));
        if (kind == 0)
            push_blanks($urandom_range(2), 1'b0);
        else if (kind <= 3)
        begin
            push_blanks($urandom_range(2), 1'b0);
            repeat ($urandom_range(3, 1))
            begin
                repeat ($urandom_range(4, 1)) add_byte(pick_plain());
                push_blanks(pick_run(max_run), 1'b0);
            end
        end
        else
        begin
            add_byte(QUOTE_CH);
            repeat ($urandom_range(3))
            begin
                repeat ($urandom_range(3, 1))
                begin
                    case ($urandom_range(5))
                        0:
                        begin
                            add_byte(QUOTE_CH);
                            add_byte(QUOTE_CH);
                        end
                        1:       add_byte(literal_delim ? delim_now : pick_plain());
                        default: add_byte(pick_plain());
                    endcase
                end
                // leave room for blanks after the closing quote
                push_blanks(pick_run(max_run - 2), 1'b1);
            end
            add_byte(QUOTE_CH);
            if (!quote_at_end && $urandom_range(2) == 0)
                push_blanks($urandom_range(2), 1'b0);
        end
    endfunction

    task automatic gen_record(input int max_run);
        int nf;
        int ending;
        nf     = $urandom_range(4, 1);
        ending = $urandom_range(9);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                add_byte(delim_now);
            gen_field(max_run, f == nf - 1 && ending >= 8);
        end
        case (ending)
            5:
            begin
                add_byte($urandom_range(1) ? CR_CH : LF_CH);
                repeat ($urandom_range(3)) add_byte(noise_byte());
            end
            6:
            begin
                add_byte(NUL_CH);
                repeat ($urandom_range(3)) add_byte(noise_byte());
            end
            7:       add_byte(delim_now);
            default: ;
        endcase
        if (line_buf.size() == 0)
            add_byte(pick_plain());
        flush_line();
    endtask

    task automatic run_phase(input logic [7:0] d, input int sidle, input int rstall,
                             input int n_beats, input int max_run);
        int target;
        if (d != delim_now || max_run > PENDING_DEPTH_DEF)
            write_delim(d);
        send_idle_pct = sidle;
        stall_pct     = rstall;
        target        = beats_sent + n_beats;
        if (max_run > PENDING_DEPTH_DEF)
        begin
            // blank run well past the buffer depth inside one field
            push_text("x");
            push_blanks(PENDING_DEPTH_DEF + 4, 1'b0);
            push_text("y");
            flush_line();
        end
        while (beats_sent < target)
        begin
            if ($urandom_range(99) < 85)
                gen_record(max_run);
            else
                repeat ($urandom_range(10, 1)) send_beat(noise_byte(), $urandom_range(5) == 0);
        end
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // quoted field with doubled quote, trimmed field, top byte value
        push_text("\"a\"\"b\": c d :");
        add_byte(8'hFF);
        flush_line();
        // LF ends the record early, the rest of the line is dropped
        push_text("x\ny");
        flush_line();
        // line ends on a closing quote still waiting for its lookahead
        push_text("\"q\"");
        flush_line();
        // line ends on the delimiter
        push_text("w:");
        flush_line();
        add_byte(NUL_CH);
        push_text("k");
        flush_line();
        add_byte(CR_CH);
        flush_line();
        drain();

        run_phase(DELIM_RESET, 0, 0, 60, PENDING_DEPTH_DEF);
        run_phase(8'h2C, 57, 0, 60, PENDING_DEPTH_DEF);    // ','
        run_phase(8'hFF, 0, 57, 40, PENDING_DEPTH_DEF);
        run_phase(NUL_CH, 37, 37, 35, PENDING_DEPTH_DEF);
        run_phase(QUOTE_CH, 37, 37, 35, PENDING_DEPTH_DEF);
        run_phase(CR_CH, 0, 0, 25, PENDING_DEPTH_DEF);
        run_phase(8'h20, 57, 0, 25, PENDING_DEPTH_DEF);
        run_phase(8'h7C, 37, 37, 40, PENDING_DEPTH_DEF + 8);   // '|', overflow last

        $display("run: %0d lines, %0d input beats, %0d tokens compared", lines_sent,
                 beats_sent, tokens_checked);
        $display("delimiters ':' ',' 0xFF NUL quote CR space '|'; blank buffer overflow at end");
        if (mismatches == 0 && tokens_left == 0)
            $display("quoted_field_tokenizer_core verification clean");
        else
            $display("quoted_field_tokenizer_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qft_pkg.sv
rtl/qft_front.sv
rtl/qft_cmd_fifo.sv
rtl/qft_back.sv
rtl/quoted_field_tokenizer_core.sv
tb/qft_token_checker.sv
tb/quoted_field_tokenizer_core_test.sv
